// ===== rtl/podi_pkg.sv =====
package podi_pkg;

	// Controller states; the datapath decodes its operands from the current phase.
	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_NSUM   = 12'b0000_0000_0010,
		ST_SHIFT  = 12'b0000_0000_0100,
		ST_SEED   = 12'b0000_0000_1000,
		ST_NY2    = 12'b0000_0001_0000,
		ST_NMY    = 12'b0000_0010_0000,
		ST_NY     = 12'b0000_0100_0000,
		ST_SCALE  = 12'b0000_1000_0000,
		ST_ROTT   = 12'b0001_0000_0000,
		ST_ROTR   = 12'b0010_0000_0000,
		ST_QMUL   = 12'b0100_0000_0000,
		ST_COMMIT = 12'b1000_0000_0000
	} podi_state_t;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} podi_acc_op_t;

	typedef enum logic [3:0] {
		WR_NONE,
		WR_NSUM,
		WR_Y2,
		WR_TN,
		WR_Y,
		WR_QN,
		WR_T,
		WR_R,
		WR_NQ
	} podi_wr_op_t;

	localparam int STEP_W = 5;
	localparam int TIME_W = 32;
	localparam int Q30    = 30;
	localparam int Y_W    = 32;
	localparam int Y2_W   = 33;
	localparam int TN_W   = 32;

	typedef struct packed {
		podi_state_t        phase;
		logic [STEP_W-1:0]  step;
		logic               issue;
		logic               load_in;
		logic               shift;
		logic               seed;
		logic               commit;
	} podi_cmd_t;

	typedef struct packed {
		logic norm_ok;
		logic norm_done;
	} podi_sts_t;

	// 1/sqrt seed in Q.30, indexed by the top three bits of the normalized norm
	localparam logic [Y_W-1:0] SEED_TAB [0:7] = '{
		32'd960383884, 32'd960383884, 32'd960383884, 32'd811672525,
		32'd715827883, 32'd647490682, 32'd595604800, 32'd554477913
	};

	// Hamilton product signs, bit (4*out_component + stored_component)
	localparam logic [15:0] QMUL_NEG = 16'b0100_0010_1000_1110;

	// multiply count of each phase
	function automatic logic [STEP_W-1:0] podi_len(input podi_state_t s);
		logic [STEP_W-1:0] n;
		n = '0;
		case (s)
			ST_NSUM:                 n = STEP_W'(4);
			ST_NY2, ST_NMY, ST_NY:   n = STEP_W'(1);
			ST_SCALE:                n = STEP_W'(4);
			ST_ROTT:                 n = STEP_W'(6);
			ST_ROTR:                 n = STEP_W'(12);
			ST_QMUL:                 n = STEP_W'(16);
			default:                 n = '0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/podi_in_if.sv =====
interface podi_in_if #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [POS_WIDTH-1:0]  delta_x;
	logic signed [POS_WIDTH-1:0]  delta_y;
	logic signed [POS_WIDTH-1:0]  delta_z;
	logic signed [QUAT_WIDTH-1:0] rot_w;
	logic signed [QUAT_WIDTH-1:0] rot_x;
	logic signed [QUAT_WIDTH-1:0] rot_y;
	logic signed [QUAT_WIDTH-1:0] rot_z;
	logic [31:0]                  time_step;

	modport source (output valid, delta_x, delta_y, delta_z, rot_w, rot_x, rot_y, rot_z,
		time_step, input ready);
	modport sink (input valid, delta_x, delta_y, delta_z, rot_w, rot_x, rot_y, rot_z,
		time_step, output ready);
endinterface

// ===== rtl/podi_out_if.sv =====
interface podi_out_if #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [POS_WIDTH-1:0]  pos_x;
	logic signed [POS_WIDTH-1:0]  pos_y;
	logic signed [POS_WIDTH-1:0]  pos_z;
	logic signed [QUAT_WIDTH-1:0] att_w;
	logic signed [QUAT_WIDTH-1:0] att_x;
	logic signed [QUAT_WIDTH-1:0] att_y;
	logic signed [QUAT_WIDTH-1:0] att_z;
	logic [31:0]                  pose_time;
	logic                         bad_rotation;

	modport source (output valid, pos_x, pos_y, pos_z, att_w, att_x, att_y, att_z,
		pose_time, bad_rotation, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, att_w, att_x, att_y, att_z,
		pose_time, bad_rotation, output ready);
endinterface

// ===== rtl/podi_ctrl.sv =====
module podi_ctrl import podi_pkg::*; #(
	parameter int NORM_ITERATIONS = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output podi_cmd_t cmd,
	input  podi_sts_t sts
);

	localparam int IT_W = (NORM_ITERATIONS > 1) ? $clog2(NORM_ITERATIONS) : 1;
	localparam logic [IT_W-1:0] LAST_IT = IT_W'(NORM_ITERATIONS - 1);

	podi_state_t       state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [IT_W-1:0]   it_q, it_d;
	logic              out_valid_q;
	logic [STEP_W-1:0] len;
	logic              phase_end;
	logic              commit_c;

	assign len       = podi_len(state_q);
	// the step counter runs on past the last multiply so the write-back lands
	assign phase_end = (cnt_q == len + STEP_W'(1));
	assign commit_c  = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.phase   = state_q;
		cmd.step    = cnt_q;
		cmd.issue   = (cnt_q < len);
		cmd.load_in = (state_q == ST_IDLE) && in_valid;
		cmd.shift   = (state_q == ST_SHIFT) && sts.norm_ok && !sts.norm_done;
		cmd.seed    = (state_q == ST_SEED);
		cmd.commit  = commit_c;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		it_d    = it_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_NSUM;
					cnt_d   = '0;
				end
			end
			ST_SHIFT: begin
				if (!sts.norm_ok) begin
					state_d = ST_ROTT;
				end else if (sts.norm_done) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				state_d = ST_NY2;
				it_d    = '0;
			end
			ST_COMMIT: begin
				if (commit_c) begin
					state_d = ST_IDLE;
				end
			end
			ST_NSUM, ST_NY2, ST_NMY, ST_NY, ST_SCALE, ST_ROTT, ST_ROTR, ST_QMUL: begin
				if (phase_end) begin
					cnt_d = '0;
					case (state_q)
						ST_NSUM:  state_d = ST_SHIFT;
						ST_NY2:   state_d = ST_NMY;
						ST_NMY:   state_d = ST_NY;
						ST_NY: begin
							if (it_q == LAST_IT) begin
								state_d = ST_SCALE;
							end else begin
								state_d = ST_NY2;
								it_d    = it_q + IT_W'(1);
							end
						end
						ST_SCALE: state_d = ST_ROTT;
						ST_ROTT:  state_d = ST_ROTR;
						ST_ROTR:  state_d = sts.norm_ok ? ST_QMUL : ST_COMMIT;
						default:  state_d = ST_COMMIT;
					endcase
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			it_q    <= it_d;
			if (commit_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_NSUM)
		else $error("accepted item did not start the norm phase");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= len + STEP_W'(1))
		else $error("step counter ran past its phase");

	a_qmul_needs_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QMUL |-> sts.norm_ok)
		else $error("quaternion product on a zero-norm increment");

	a_scale_needs_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |-> sts.norm_ok)
		else $error("scaling on a zero-norm increment");

endmodule

// ===== rtl/podi_datapath.sv =====
module podi_datapath import podi_pkg::*; #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  podi_cmd_t                    cmd,
	output podi_sts_t                    sts,
	input  logic signed [POS_WIDTH-1:0]  delta_x,
	input  logic signed [POS_WIDTH-1:0]  delta_y,
	input  logic signed [POS_WIDTH-1:0]  delta_z,
	input  logic signed [QUAT_WIDTH-1:0] rot_w,
	input  logic signed [QUAT_WIDTH-1:0] rot_x,
	input  logic signed [QUAT_WIDTH-1:0] rot_y,
	input  logic signed [QUAT_WIDTH-1:0] rot_z,
	input  logic [TIME_W-1:0]            time_step,
	output logic signed [POS_WIDTH-1:0]  pos_x,
	output logic signed [POS_WIDTH-1:0]  pos_y,
	output logic signed [POS_WIDTH-1:0]  pos_z,
	output logic signed [QUAT_WIDTH-1:0] att_w,
	output logic signed [QUAT_WIDTH-1:0] att_x,
	output logic signed [QUAT_WIDTH-1:0] att_y,
	output logic signed [QUAT_WIDTH-1:0] att_z,
	output logic [TIME_W-1:0]            pose_time,
	output logic                         bad_rotation
);

	localparam int QF    = QUAT_WIDTH - 1;
	localparam int TW    = POS_WIDTH + 3;          // rounded cross product
	localparam int MW    = 2 * QF + 3;             // quaternion norm
	localparam int MA    = (TW > MW + 1) ? TW : MW + 1;
	localparam int MUL_W = (MA > Y2_W + 1) ? MA : Y2_W + 1;
	localparam int ACC_W = 2 * MUL_W;
	localparam int KW    = $clog2(QUAT_WIDTH) + 2;
	localparam int SH_W  = $clog2(ACC_W);

	localparam logic signed [MUL_W-1:0] ONE_Q     = MUL_W'(1) <<< QF;
	localparam logic signed [ACC_W-1:0] HALF_QF   = ACC_W'(1) <<< (QF - 1);
	localparam logic signed [ACC_W-1:0] HALF_T    = ACC_W'(1) <<< (QF - 2);
	localparam logic signed [ACC_W-1:0] Q_MAX     = (ACC_W'(1) <<< QF) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] Q_MIN     = ~Q_MAX;
	localparam logic signed [ACC_W-1:0] P_MAX     = (ACC_W'(1) <<< (POS_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] P_MIN     = ~P_MAX;
	localparam logic signed [ACC_W-1:0] THREE_Q30 = ACC_W'(64'd3 << Q30);
	localparam logic signed [ACC_W-1:0] Y_MAX     = ACC_W'(64'd1 << 31);
	localparam logic signed [QUAT_WIDTH-1:0] ATT_ONE = {1'b0, {QF{1'b1}}};

	function automatic logic signed [QUAT_WIDTH-1:0] sat_q(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] c;
		c = (x > Q_MAX) ? Q_MAX : ((x < Q_MIN) ? Q_MIN : x);
		return QUAT_WIDTH'(c);
	endfunction

	function automatic logic signed [POS_WIDTH-1:0] sat_p(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] c;
		c = (x > P_MAX) ? P_MAX : ((x < P_MIN) ? P_MIN : x);
		return POS_WIDTH'(c);
	endfunction

	// item operands
	logic signed [POS_WIDTH-1:0]  v_q [3];
	logic signed [QUAT_WIDTH-1:0] q_q [4];
	logic [TIME_W-1:0]            ts_q;
	// normalization
	logic [MW-1:0]                m_q;
	logic signed [KW-1:0]         k_q;
	logic                         ok_q;
	logic [Y_W-1:0]               y_q;
	logic [Y2_W-1:0]              y2_q;
	logic [TN_W-1:0]              tn_q;
	// rotation and product
	logic signed [TW-1:0]         t_q [3];
	logic signed [QUAT_WIDTH-1:0] nq_q [4];
	// pose
	logic signed [POS_WIDTH-1:0]  pos_q [3];
	logic signed [QUAT_WIDTH-1:0] att_q [4];
	logic [TIME_W-1:0]            elapsed_q;
	// output register
	logic signed [POS_WIDTH-1:0]  opos_q [3];
	logic signed [QUAT_WIDTH-1:0] oatt_q [4];
	logic [TIME_W-1:0]            otime_q;
	logic                         obad_q;
	// multiply-accumulate pipe
	logic signed [ACC_W-1:0]      prod_s1;
	logic                         issue_s1;
	podi_acc_op_t                 accop_s1;
	podi_wr_op_t                  wr_s1, wr_s2;
	logic [1:0]                   grp_s1, grp_s2;
	logic signed [ACC_W-1:0]      acc_q;

	logic signed [MUL_W-1:0]      opa, opb;
	podi_acc_op_t                 acc_op;
	podi_wr_op_t                  wr_op;
	logic [1:0]                   grp;
	logic [1:0]                   g2, j2, g1, ai, bi;
	logic                         j1;

	assign g2 = cmd.step[3:2];
	assign j2 = cmd.step[1:0];
	assign g1 = cmd.step[2:1];
	assign j1 = cmd.step[0];

	// operand select per phase and step
	always_comb begin
		opa    = '0;
		opb    = '0;
		acc_op = ACC_ADD;
		wr_op  = WR_NONE;
		grp    = '0;
		ai     = '0;
		bi     = '0;
		unique case (cmd.phase)
			ST_NSUM: begin
				opa    = MUL_W'(q_q[j2]);
				opb    = MUL_W'(q_q[j2]);
				acc_op = (j2 == 2'd0) ? ACC_LOAD : ACC_ADD;
				wr_op  = (j2 == 2'd3) ? WR_NSUM : WR_NONE;
			end
			ST_NY2: begin
				opa    = MUL_W'(y_q);
				opb    = MUL_W'(y_q);
				acc_op = ACC_LOAD;
				wr_op  = WR_Y2;
			end
			ST_NMY: begin
				opa    = MUL_W'(m_q);
				opb    = MUL_W'(y2_q);
				acc_op = ACC_LOAD;
				wr_op  = WR_TN;
			end
			ST_NY: begin
				opa    = MUL_W'(y_q);
				opb    = MUL_W'(tn_q);
				acc_op = ACC_LOAD;
				wr_op  = WR_Y;
			end
			ST_SCALE: begin
				opa    = MUL_W'(q_q[j2]);
				opb    = MUL_W'(y_q);
				acc_op = ACC_LOAD;
				wr_op  = WR_QN;
				grp    = j2;
			end
			ST_ROTT: begin
				// t = 2 (u x v): attitude index ai, translation index bi
				case ({g1, j1})
					3'b000:  begin ai = 2'd2; bi = 2'd2; end
					3'b001:  begin ai = 2'd3; bi = 2'd1; end
					3'b010:  begin ai = 2'd3; bi = 2'd0; end
					3'b011:  begin ai = 2'd1; bi = 2'd2; end
					3'b100:  begin ai = 2'd1; bi = 2'd1; end
					3'b101:  begin ai = 2'd2; bi = 2'd0; end
					default: begin ai = 2'd0; bi = 2'd0; end
				endcase
				opa    = MUL_W'(att_q[ai]);
				opb    = MUL_W'(v_q[bi]);
				acc_op = j1 ? ACC_SUB : ACC_LOAD;
				wr_op  = j1 ? WR_T : WR_NONE;
				grp    = g1;
			end
			ST_ROTR: begin
				// v*2^QF + w*t + (u x t)
				case ({g2, j2[0]})
					3'b000:  begin ai = 2'd2; bi = 2'd2; end
					3'b001:  begin ai = 2'd3; bi = 2'd1; end
					3'b010:  begin ai = 2'd3; bi = 2'd0; end
					3'b011:  begin ai = 2'd1; bi = 2'd2; end
					3'b100:  begin ai = 2'd1; bi = 2'd1; end
					3'b101:  begin ai = 2'd2; bi = 2'd0; end
					default: begin ai = 2'd0; bi = 2'd0; end
				endcase
				case (j2)
					2'd0: begin
						opa = MUL_W'(v_q[g2]);
						opb = ONE_Q;
					end
					2'd1: begin
						opa = MUL_W'(att_q[0]);
						opb = MUL_W'(t_q[g2]);
					end
					default: begin
						opa = MUL_W'(att_q[ai]);
						opb = MUL_W'(t_q[bi]);
					end
				endcase
				acc_op = (j2 == 2'd0) ? ACC_LOAD : ((j2 == 2'd3) ? ACC_SUB : ACC_ADD);
				wr_op  = (j2 == 2'd3) ? WR_R : WR_NONE;
				grp    = g2;
			end
			ST_QMUL: begin
				opa    = MUL_W'(att_q[j2]);
				opb    = MUL_W'(q_q[g2 ^ j2]);
				acc_op = (j2 == 2'd0) ? ACC_LOAD :
					(QMUL_NEG[{g2, j2}] ? ACC_SUB : ACC_ADD);
				wr_op  = (j2 == 2'd3) ? WR_NQ : WR_NONE;
				grp    = g2;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// write-back values from the finished accumulator
	logic [MW-1:0]           n_v;
	logic [SH_W-1:0]         sh_amt;
	logic signed [ACC_W-1:0] half_v, rnd_v, rnd_q, rnd_t, tnf, yf, psum;
	logic [TN_W-1:0]         tn_c;
	logic [Y_W-1:0]          y_c;
	logic [TIME_W:0]         tsum;
	logic [TIME_W-1:0]       elapsed_c;

	assign n_v       = acc_q[MW-1:0];
	assign sh_amt    = SH_W'(Q30 - int'(k_q));
	assign half_v    = ACC_W'(1) <<< (sh_amt - SH_W'(1));
	assign rnd_v     = (acc_q + half_v) >>> sh_amt;
	assign rnd_q     = (acc_q + HALF_QF) >>> QF;
	assign rnd_t     = (acc_q + HALF_T) >>> (QF - 1);
	assign tnf       = THREE_Q30 - (acc_q >>> (2 * QF));
	assign tn_c      = tnf[ACC_W-1] ? '0 : TN_W'(tnf);
	assign yf        = acc_q >>> 31;
	assign y_c       = (yf > Y_MAX) ? Y_W'(Y_MAX) : Y_W'(yf);
	assign psum      = ACC_W'(pos_q[grp_s2]) + rnd_q;
	assign tsum      = {1'b0, elapsed_q} + {1'b0, ts_q};
	assign elapsed_c = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];

	assign sts.norm_ok   = ok_q;
	assign sts.norm_done = |m_q[MW-1:2*QF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1  <= 1'b0;
			wr_s1     <= WR_NONE;
			wr_s2     <= WR_NONE;
			pos_q     <= '{default: '0};
			att_q     <= '{ATT_ONE, '0, '0, '0};
			elapsed_q <= '0;
		end else begin
			issue_s1 <= cmd.issue;
			wr_s1    <= cmd.issue ? wr_op : WR_NONE;
			wr_s2    <= wr_s1;
			if (wr_s2 == WR_R) begin
				pos_q[grp_s2] <= sat_p(psum);
			end
			if (cmd.commit) begin
				if (ok_q) begin
					att_q <= nq_q;
				end
				elapsed_q <= elapsed_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= opa * opb;
		accop_s1 <= acc_op;
		grp_s1   <= grp;
		grp_s2   <= grp_s1;
		if (issue_s1) begin
			case (accop_s1)
				ACC_LOAD: acc_q <= prod_s1;
				ACC_ADD:  acc_q <= acc_q + prod_s1;
				ACC_SUB:  acc_q <= acc_q - prod_s1;
				default:  acc_q <= acc_q;
			endcase
		end
		if (cmd.load_in) begin
			v_q  <= '{delta_x, delta_y, delta_z};
			q_q  <= '{rot_w, rot_x, rot_y, rot_z};
			ts_q <= time_step;
		end
		// bring the norm into [1,4) by even shifts
		if (cmd.shift) begin
			if (m_q[MW-1:2*QF-2] == '0) begin
				m_q <= m_q << 4;
				k_q <= k_q + KW'(2);
			end else begin
				m_q <= m_q << 2;
				k_q <= k_q + KW'(1);
			end
		end
		if (cmd.seed) begin
			y_q <= SEED_TAB[m_q[2*QF+1 -: 3]];
		end
		case (wr_s2)
			WR_NSUM: begin
				ok_q <= (n_v != '0);
				if (n_v[MW-1]) begin
					m_q <= n_v >> 2;
					k_q <= '1;
				end else begin
					m_q <= n_v;
					k_q <= '0;
				end
			end
			WR_Y2:   y2_q <= acc_q[Q30 +: Y2_W];
			WR_TN:   tn_q <= tn_c;
			WR_Y:    y_q <= y_c;
			WR_QN:   q_q[grp_s2] <= sat_q(rnd_v);
			WR_T:    t_q[grp_s2] <= TW'(rnd_t);
			WR_NQ:   nq_q[grp_s2] <= sat_q(rnd_q);
			default: ;
		endcase
		if (cmd.commit) begin
			opos_q  <= pos_q;
			oatt_q  <= ok_q ? nq_q : att_q;
			otime_q <= elapsed_c;
			obad_q  <= !ok_q;
		end
	end

	assign pos_x        = opos_q[0];
	assign pos_y        = opos_q[1];
	assign pos_z        = opos_q[2];
	assign att_w        = oatt_q[0];
	assign att_x        = oatt_q[1];
	assign att_y        = oatt_q[2];
	assign att_z        = oatt_q[3];
	assign pose_time    = otime_q;
	assign bad_rotation = obad_q;

endmodule

// ===== rtl/pose6d_odometry_integrator.sv =====
// Quaternion dead-reckoning pose integrator. Each odometry item (body-frame
// translation, increment quaternion, time step) normalizes the increment
// quaternion by a Newton inverse square root, rotates the translation by the
// stored orientation into the world position, multiplies the orientation by
// the increment and adds the time step; one pose item comes out per input
// item. Position and time saturate; a zero-norm increment leaves the
// orientation unchanged and sets bad_rotation. After reset the pose is at the
// origin with orientation w = max, x = y = z = 0. Items are handled one at a
// time, since the single shared multiply-accumulate unit does every product
// in turn; a zero-norm increment skips the normalization and the quaternion
// product. The finished pose sits in an output register, so the next item
// is accepted while the previous result waits.
module pose6d_odometry_integrator import podi_pkg::*; #(
	parameter int POS_WIDTH       = 32,
	parameter int QUAT_WIDTH      = 16,
	parameter int NORM_ITERATIONS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	podi_in_if.sink           in_ch,
	podi_out_if.source        out_ch
);

	podi_cmd_t cmd;
	podi_sts_t sts;
	logic      in_ready;
	logic      out_valid;

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

	podi_ctrl #(
		.NORM_ITERATIONS(NORM_ITERATIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	podi_datapath #(
		.POS_WIDTH  (POS_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.delta_x      (in_ch.delta_x),
		.delta_y      (in_ch.delta_y),
		.delta_z      (in_ch.delta_z),
		.rot_w        (in_ch.rot_w),
		.rot_x        (in_ch.rot_x),
		.rot_y        (in_ch.rot_y),
		.rot_z        (in_ch.rot_z),
		.time_step    (in_ch.time_step),
		.pos_x        (out_ch.pos_x),
		.pos_y        (out_ch.pos_y),
		.pos_z        (out_ch.pos_z),
		.att_w        (out_ch.att_w),
		.att_x        (out_ch.att_x),
		.att_y        (out_ch.att_y),
		.att_z        (out_ch.att_z),
		.pose_time    (out_ch.pose_time),
		.bad_rotation (out_ch.bad_rotation)
	);

endmodule
